/* hw/rtl/sscm_pkg.sv */
// ----------------------------------------------------------------------------
// sscm_pkg: shared types and constants of the supersequence merge block
// Item structs, function codes, trace directions and sequencer states.
// ----------------------------------------------------------------------------
package sscm_pkg;

  localparam int unsigned MaxLenDefault = 64;

  typedef enum logic [1:0] {
    FUNC_BASE  = 2'd0,
    FUNC_PATH  = 2'd1,
    FUNC_FETCH = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    PH_BASE  = 2'd0,
    PH_PATH  = 2'd1,
    PH_READY = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    DIR_SKIP  = 2'd0,
    DIR_INS   = 2'd1,
    DIR_MATCH = 2'd2
  } dir_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW0,
    ST_DP_ROW,
    ST_DP_RD,
    ST_DP_WR,
    ST_BT_START,
    ST_BT_RD,
    ST_BT_DEC,
    ST_FIN_RD,
    ST_FIN_WR,
    ST_FETCH_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] node_id;
    logic        seq_last;
  } in_t;

  typedef struct packed {
    logic [31:0] merged_id;
    logic        merged_last;
    logic        fetch_status;
  } out_t;

endpackage

/* hw/rtl/supersequence_merge_dp_top.sv */
// A fetch reads the merge buffer, then ST_FETCH_OUT registers the result.
// The last path load runs the merge: ST_ROW0 fills row 0, then each further
// base row runs ST_DP_ROW and ST_DP_RD/ST_DP_WR per cell in the shared cell unit,
// then ST_BT_RD/ST_BT_DEC per backtrace step; the block takes no item meanwhile.
// Reset: asynchronous, clears lengths, counters and phase; memories are not cleared.
// ----------------------------------------------------------------------------
// supersequence_merge_dp_top: supersequence merge by dynamic programming
// Loads a base sequence and a path, aligns them with one shared cell unit
// under a sequencer, backtraces the merge and hands it out item by item.
// ----------------------------------------------------------------------------
module supersequence_merge_dp_top #(
  parameter int unsigned MAX_LEN = sscm_pkg::MaxLenDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sscm_pkg::in_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sscm_pkg::out_t out_data_o
);
  import sscm_pkg::*;

  localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned SW = $clog2(MAX_LEN + 1);
  localparam int unsigned MD = 2 * MAX_LEN - 1;
  localparam int unsigned KW = $clog2(MD);
  localparam int unsigned CW = $clog2(MD + 1);
  localparam int unsigned TW = 2 * IW;

  // storage
  logic [31:0]   base_mem  [MAX_LEN];
  logic [31:0]   path_mem  [MAX_LEN];
  logic [SW-1:0] score_mem [MAX_LEN];
  logic [1:0]    trace_mem [2**TW];
  logic [31:0]   merge_mem [MD];

  state_e        state_q, state_d;
  phase_e        phase_q, phase_d;
  logic [LW-1:0] base_len_q, base_len_d, path_len_q, path_len_d;
  logic [CW-1:0] count_q, count_d, ptr_q, ptr_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d;
  logic [KW-1:0] k_q, k_d;
  logic [SW-1:0] left_q, left_d, diag_q, diag_d;
  logic          hit_q, hit_d, last_q, last_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  // memory port controls
  logic          base_we, path_we, score_we, trace_we, merge_we;
  logic [IW-1:0] base_wa, path_wa, score_wa;
  logic [SW-1:0] score_wd;
  logic [1:0]    trace_wd;
  logic [KW-1:0] merge_wa, merge_ra;
  logic [31:0]   merge_wd;
  logic          base_re, path_re, score_re, trace_re, merge_re;
  logic [IW-1:0] base_ra, path_ra;
  logic [31:0]   base_rd_q, path_rd_q, merge_rd_q;
  logic [SW-1:0] score_rd_q;
  logic [1:0]    trace_rd_q;

  logic          accept;
  logic [IW-1:0] m_last, n_last;
  logic [LW-1:0] base_len_eff;
  logic [SW-1:0] best;
  dir_e          cell_dir;
  dir_e          bt_dir;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  assign m_last = IW'(base_len_q - LW'(1));
  assign n_last = IW'(path_len_q - LW'(1));
  assign base_len_eff = (phase_q != PH_BASE) ? '0 : base_len_q;

  sscm_cell #(.SW(SW)) u_cell (
    .above_i (score_rd_q),
    .left_i  (left_q),
    .diag_i  (diag_q),
    .eq_i    (base_rd_q == path_rd_q),
    .best_o  (best),
    .dir_o   (cell_dir)
  );

  // edges of the grid override the stored choice
  always_comb begin
    bt_dir = dir_e'(trace_rd_q);
    if (j_q == '0) begin
      bt_dir = DIR_SKIP;
    end else if (i_q == '0) begin
      bt_dir = DIR_INS;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    base_len_d  = base_len_q;
    path_len_d  = path_len_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    left_d      = left_q;
    diag_d      = diag_q;
    hit_d       = hit_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    base_we = 1'b0; base_wa = '0;
    path_we = 1'b0; path_wa = '0;
    score_we = 1'b0; score_wa = '0; score_wd = '0;
    trace_we = 1'b0; trace_wd = DIR_SKIP;
    merge_we = 1'b0; merge_wa = '0; merge_wd = '0;
    base_re = 1'b0; base_ra = '0;
    path_re = 1'b0; path_ra = '0;
    score_re = 1'b0; trace_re = 1'b0;
    merge_re = 1'b0;
    merge_ra = KW'(count_q - ptr_q - CW'(1));

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_e'(in_data_i.func))
            FUNC_BASE: begin
              // a base load outside the base phase opens a new job
              if (phase_q != PH_BASE) begin
                path_len_d = '0;
                count_d    = '0;
                ptr_d      = '0;
                phase_d    = PH_BASE;
              end
              base_len_d = base_len_eff;
              if (base_len_eff < LW'(MAX_LEN)) begin
                base_we    = 1'b1;
                base_wa    = IW'(base_len_eff);
                base_len_d = base_len_eff + LW'(1);
              end
              if (in_data_i.seq_last) begin
                phase_d = PH_PATH;
              end
            end
            FUNC_PATH: begin
              if (phase_q == PH_PATH) begin
                if (path_len_q < LW'(MAX_LEN)) begin
                  path_we    = 1'b1;
                  path_wa    = IW'(path_len_q);
                  path_len_d = path_len_q + LW'(1);
                end
                if (in_data_i.seq_last) begin
                  phase_d = PH_READY;
                  j_d     = '0;
                  state_d = ST_ROW0;
                end
              end
            end
            FUNC_FETCH: begin
              hit_d  = (phase_q == PH_READY) && (ptr_q < count_q);
              last_d = (ptr_q + CW'(1)) == count_q;
              if ((phase_q == PH_READY) && (ptr_q < count_q)) begin
                merge_re = 1'b1;
                ptr_d    = ptr_q + CW'(1);
              end
              state_d = ST_FETCH_OUT;
            end
            default: ;
          endcase
        end
      end
      ST_FETCH_OUT: begin
        out_d.merged_id    = hit_q ? merge_rd_q : 32'd0;
        out_d.merged_last  = hit_q && last_q;
        out_d.fetch_status = !hit_q;
        out_valid_d        = 1'b1;
        state_d            = ST_IDLE;
      end
      ST_ROW0: begin
        score_we = 1'b1;
        score_wa = j_q;
        score_wd = SW'(j_q);
        j_d      = j_q + IW'(1);
        if (j_q == n_last) begin
          i_d = IW'(1);
          j_d = IW'(1);
          if ((m_last != '0) && (n_last != '0)) begin
            state_d = ST_DP_ROW;
          end else begin
            state_d = ST_BT_START;
          end
        end
      end
      ST_DP_ROW: begin
        // column 0 stays at cost 0, so left and diag start at 0
        base_re = 1'b1;
        base_ra = i_q;
        left_d  = '0;
        diag_d  = '0;
        j_d     = IW'(1);
        state_d = ST_DP_RD;
      end
      ST_DP_RD: begin
        score_re = 1'b1;
        path_re  = 1'b1;
        path_ra  = j_q;
        state_d  = ST_DP_WR;
      end
      ST_DP_WR: begin
        score_we = 1'b1;
        score_wa = j_q;
        score_wd = best;
        trace_we = 1'b1;
        trace_wd = cell_dir;
        diag_d   = score_rd_q;
        left_d   = best;
        j_d      = j_q + IW'(1);
        state_d  = ST_DP_RD;
        if (j_q == n_last) begin
          i_d = i_q + IW'(1);
          if (i_q == m_last) begin
            state_d = ST_BT_START;
          end else begin
            state_d = ST_DP_ROW;
          end
        end
      end
      ST_BT_START: begin
        i_d = m_last;
        j_d = n_last;
        k_d = '0;
        if ((m_last == '0) && (n_last == '0)) begin
          state_d = ST_FIN_RD;
        end else begin
          state_d = ST_BT_RD;
        end
      end
      ST_BT_RD: begin
        trace_re = 1'b1;
        base_re  = 1'b1;
        base_ra  = i_q;
        path_re  = 1'b1;
        path_ra  = j_q;
        state_d  = ST_BT_DEC;
      end
      ST_BT_DEC: begin
        // buffer fills in reverse; fetch reads it from the top down
        merge_we = 1'b1;
        merge_wa = k_q;
        k_d      = k_q + KW'(1);
        if (bt_dir == DIR_INS) begin
          merge_wd = path_rd_q;
          j_d      = j_q - IW'(1);
        end else begin
          merge_wd = base_rd_q;
          i_d      = i_q - IW'(1);
          if (bt_dir == DIR_MATCH) begin
            j_d = j_q - IW'(1);
          end
        end
        if ((i_d == '0) && (j_d == '0)) begin
          state_d = ST_FIN_RD;
        end else begin
          state_d = ST_BT_RD;
        end
      end
      ST_FIN_RD: begin
        base_re = 1'b1;
        base_ra = '0;
        state_d = ST_FIN_WR;
      end
      ST_FIN_WR: begin
        merge_we = 1'b1;
        merge_wa = k_q;
        merge_wd = base_rd_q;
        count_d  = CW'(k_q) + CW'(1);
        ptr_d    = '0;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_BASE;
      base_len_q  <= '0;
      path_len_q  <= '0;
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      base_len_q  <= base_len_d;
      path_len_q  <= path_len_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
    left_q <= left_d;
    diag_q <= diag_d;
    hit_q  <= hit_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (base_we) begin
      base_mem[base_wa] <= in_data_i.node_id;
    end
    if (base_re) begin
      base_rd_q <= base_mem[base_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (path_we) begin
      path_mem[path_wa] <= in_data_i.node_id;
    end
    if (path_re) begin
      path_rd_q <= path_mem[path_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (score_we) begin
      score_mem[score_wa] <= score_wd;
    end
    if (score_re) begin
      score_rd_q <= score_mem[j_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (trace_we) begin
      trace_mem[{i_q, j_q}] <= trace_wd;
    end
    if (trace_re) begin
      trace_rd_q <= trace_mem[{i_q, j_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (merge_we) begin
      merge_mem[merge_wa] <= merge_wd;
    end
    if (merge_re) begin
      merge_rd_q <= merge_mem[merge_ra];
    end
  end

endmodule

/* hw/rtl/sscm_cell.sv */
// ----------------------------------------------------------------------------
// sscm_cell: DP cell evaluation unit
// Picks the cheapest of skip, insert and match; ties keep the earlier choice.
// ----------------------------------------------------------------------------
module sscm_cell #(
  parameter int unsigned SW = 7
) (
  input  logic [SW-1:0]       above_i,
  input  logic [SW-1:0]       left_i,
  input  logic [SW-1:0]       diag_i,
  input  logic                eq_i,
  output logic [SW-1:0]       best_o,
  output sscm_pkg::dir_e      dir_o
);
  import sscm_pkg::*;

  logic [SW-1:0] ins_cost;
  logic [SW-1:0] best1;
  dir_e          dir1;

  assign ins_cost = left_i + SW'(1);

  always_comb begin
    best1 = above_i;
    dir1  = DIR_SKIP;
    if (ins_cost < above_i) begin
      best1 = ins_cost;
      dir1  = DIR_INS;
    end
    best_o = best1;
    dir_o  = dir1;
    if (eq_i && (diag_i < best1)) begin
      best_o = diag_i;
      dir_o  = DIR_MATCH;
    end
  end

endmodule

/* test/supersequence_merge_dp_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supersequence_merge_dp_top_tb: self-checking bench for the supersequence merge
// Loads base sequences and paths, fetches the merged result and compares each
// fetched item against a software merge with the same tie rules.
// ----------------------------------------------------------------------------
module supersequence_merge_dp_top_tb;
  import sscm_pkg::*;

  localparam int unsigned MaxLen = 64;
  localparam int unsigned MergeDepth = 2 * MaxLen - 1;
  localparam longint CycleLimit = 4000000;

  class merge_scoreboard;
    logic [31:0] base_q [MaxLen];
    logic [31:0] path_q [MaxLen];
    int unsigned base_n, path_n, merge_n, fetch_idx;
    phase_e      ph;
    logic [31:0] merge_buf [MergeDepth];
    out_t        pending_q [$];
    int unsigned n_fail, n_checked, n_merges;

    function void clear();
      base_n = 0; path_n = 0; merge_n = 0; fetch_idx = 0; ph = PH_BASE;
      pending_q.delete(); n_fail = 0; n_checked = 0; n_merges = 0;
    endfunction

    function void build_merge();
      int unsigned row [MaxLen];
      dir_e        dirs [MaxLen][MaxLen];
      int unsigned diag, above, best, i, j, k;
      dir_e        d;
      logic [31:0] rev [MergeDepth];
      for (j = 0; j < path_n; j++) begin
        row[j] = j; dirs[0][j] = DIR_INS;
      end
      for (i = 1; i < base_n; i++) begin
        diag = row[0]; dirs[i][0] = DIR_SKIP; row[0] = 0;
        for (j = 1; j < path_n; j++) begin
          above = row[j]; best = above; d = DIR_SKIP;
          if (row[j-1] + 1 < best) begin
            best = row[j-1] + 1; d = DIR_INS;
          end
          if (base_q[i] == path_q[j] && diag < best) begin
            best = diag; d = DIR_MATCH;
          end
          diag = above; row[j] = best; dirs[i][j] = d;
        end
      end
      i = base_n - 1; j = path_n - 1; k = 0;
      while ((i != 0 || j != 0) && k < MergeDepth - 1) begin
        d = dirs[i][j];
        if (j == 0) d = DIR_SKIP;
        else if (i == 0) d = DIR_INS;
        if (d == DIR_INS) begin
          rev[k] = path_q[j]; k++; j--;
        end else begin
          rev[k] = base_q[i]; k++; i--;
          if (d == DIR_MATCH) j--;
        end
      end
      rev[k] = base_q[0]; k++;
      for (i = 0; i < k; i++) merge_buf[i] = rev[k-1-i];
      merge_n = k; fetch_idx = 0; n_merges++;
    endfunction

    function void note_input(in_t it);
      out_t r;
      case (it.func)
        FUNC_BASE: begin
          if (ph != PH_BASE) begin
            base_n = 0; path_n = 0; merge_n = 0; fetch_idx = 0; ph = PH_BASE;
          end
          if (base_n < MaxLen) begin
            base_q[base_n] = it.node_id; base_n++;
          end
          if (it.seq_last) ph = PH_PATH;
        end
        FUNC_PATH: begin
          if (ph == PH_PATH) begin
            if (path_n < MaxLen) begin
              path_q[path_n] = it.node_id; path_n++;
            end
            if (it.seq_last) begin
              build_merge(); ph = PH_READY;
            end
          end
        end
        FUNC_FETCH: begin
          if (ph == PH_READY && fetch_idx < merge_n) begin
            r.merged_id = merge_buf[fetch_idx];
            r.merged_last = (fetch_idx + 1 == merge_n);
            r.fetch_status = 1'b0;
            fetch_idx++;
          end else r = '{32'd0, 1'b0, 1'b1};
          pending_q = {pending_q, r};
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        n_fail++;
        return;
      end
      want = pending_q.pop_front();
      n_checked++;
      if (got.merged_id !== want.merged_id || got.merged_last !== want.merged_last ||
          got.fetch_status !== want.fetch_status) begin
        $display("%0t: mismatch, expected id=%h last=%b status=%b, actual id=%h last=%b status=%b",
                 $realtime, want.merged_id, want.merged_last, want.fetch_status,
                 got.merged_id, got.merged_last, got.fetch_status);
        n_fail++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  in_t  in_data;
  out_t out_data;
  int unsigned send_idle_pct, recv_stall_pct, n_sent;
  longint cycles;
  merge_scoreboard sb;

  supersequence_merge_dp_top #(.MAX_LEN(MaxLen)) DUT (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_data_o(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_valid && in_ready) sb.note_input(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("supersequence_merge_dp_top_tb NOT OK");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_item(input logic [1:0] fn, input logic [31:0] id, input logic lst);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_data = '{fn, id, lst};
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_id(int unsigned alpha);
    case ($urandom_range(9))
      0: return 32'hFFFF_FFFF;
      1: return $urandom;
      default: return $urandom_range(alpha - 1);
    endcase
  endfunction

  // load a base and a path, then fetch the whole merge plus some extras
  task automatic run_job(int unsigned na, int unsigned nb, int unsigned alpha, int unsigned extra);
    int unsigned i, fetches;
    for (i = 0; i < na; i++) send_item(FUNC_BASE, pick_id(alpha), i == na - 1);
    for (i = 0; i < nb; i++) send_item(FUNC_PATH, pick_id(alpha), i == nb - 1);
    fetches = sb.merge_n + extra;
    for (i = 0; i < fetches; i++) send_item(FUNC_FETCH, $urandom, 1'($urandom_range(1)));
  endtask

  int unsigned k, ph_idx, na, nb;

  initial begin
    sb = new();
    sb.clear();
    cycles = 0; n_sent = 0;
    in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed: fetch with nothing ready, unknown func, early path load
    send_item(FUNC_FETCH, 32'hFFFF_FFFF, 1'b1);
    send_item(2'd3, 32'hFFFF_FFFF, 1'b1);
    send_item(FUNC_PATH, 32'h1234_5678, 1'b1);
    send_item(FUNC_BASE, 32'hFFFF_FFFF, 1'b1);
    send_item(FUNC_PATH, 32'h0000_0000, 1'b1);
    send_item(FUNC_FETCH, 32'h0, 1'b0);
    send_item(FUNC_FETCH, 32'h0, 1'b0);
    send_item(FUNC_FETCH, 32'h0, 1'b0);
    // equal sequences, then base reload mid-result
    send_item(FUNC_BASE, 32'hA, 1'b0);
    send_item(FUNC_BASE, 32'hB, 1'b1);
    send_item(FUNC_PATH, 32'hA, 1'b0);
    send_item(FUNC_PATH, 32'hB, 1'b1);
    send_item(FUNC_FETCH, 32'h0, 1'b0);
    send_item(FUNC_BASE, 32'h5555_AAAA, 1'b0);
    send_item(FUNC_BASE, 32'hAAAA_5555, 1'b1);
    send_item(FUNC_PATH, 32'h7, 1'b0);
    send_item(FUNC_PATH, 32'hAAAA_5555, 1'b1);
    for (k = 0; k < 5; k++) send_item(FUNC_FETCH, 32'h0, 1'b0);
    drain();
    // overflow: both sequences past the limit, so both are held at full length
    run_job(MaxLen + 2, MaxLen + 2, 4, 2);
    drain();

    for (ph_idx = 0; ph_idx < 4; ph_idx++) begin
      send_idle_pct  = (ph_idx == 1) ? 86 : (ph_idx == 3) ? 38 : 0;
      recv_stall_pct = (ph_idx == 2) ? 86 : (ph_idx == 3) ? 38 : 0;
      for (k = 0; k < 4; k++) begin
        na = $urandom_range(1, 6); nb = $urandom_range(1, 6);
        if ($urandom_range(9) == 0) begin
          na = $urandom_range(1, 20); nb = $urandom_range(1, 20);
        end
        if ($urandom_range(7) == 0)
          send_item(2'($urandom_range(3)), $urandom, 1'($urandom_range(1)));  // noise
        run_job(na, nb, $urandom_range(2, 6), $urandom_range(0, 1));
      end
      drain();  // sender holds off until all results are in
    end
    drain();
    repeat (20) @(negedge clk);
    $display("sent %0d items over %0d merges, checked %0d fetch results",
             n_sent, sb.n_merges, sb.n_checked);
    if (sb.n_fail == 0 && sb.pending_q.size() == 0)
      $display("supersequence_merge_dp_top_tb OK");
    else
      $display("supersequence_merge_dp_top_tb NOT OK");
    $finish;
  end
endmodule
